// File: src/otsu_pkg.sv
// Package for the Otsu threshold finder: sequencer states and fixed field widths.
// No dependencies; otsu_if and the top level import it.
package otsu_pkg;

    // Fixed widths of the request fields
    localparam int PIXEL_W = 8;
    localparam int THR_W   = 8;

    // Sequencer states of the top level
    typedef enum logic [3:0] {
        ST_CLEAR,   // clearing pass over the histogram after reset
        ST_ACCUM,   // taking pixels, one per clock
        ST_DRAIN,   // let the last histogram write land
        ST_READ,    // read bin t, write zero behind it
        ST_LOAD,    // take bin count, update class-0 count
        ST_MUL_TH,  // t * h
        ST_MUL_A,   // s0 * N
        ST_MUL_B,   // S * n0, then |difference|
        ST_MUL_P,   // n0 * n1
        ST_MUL_DD,  // d * d
        ST_MUL_L,   // d^2 * best_p
        ST_MUL_R,   // best_d2 * p, then compare
        ST_NEXT     // step t or post the result
    } t_state;

endpackage

// File: src/otsu_if.sv
// Handshake channels of the Otsu threshold finder: pixel requests in, results out.
// Depends on otsu_pkg for the field widths.
interface otsu_pix_if;
    import otsu_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               last;

    modport source (output valid, output pixel, output last, input ready);
    modport sink   (input valid, input pixel, input last, output ready);
endinterface

interface otsu_res_if;
    import otsu_pkg::*;

    logic             valid;
    logic             ready;
    logic [THR_W-1:0] threshold;
    logic             found;

    modport source (output valid, output threshold, output found, input ready);
    modport sink   (input valid, input threshold, input found, output ready);
endinterface

// File: src/otsu_hist.sv
// Histogram memory: one-per-clock increment with read-modify-write forwarding,
// and a scan port that reads a bin and clears it in the same cycle. No dependencies.
module otsu_hist #(
    parameter int LEVELS = 256,
    parameter int CNT_W  = 17
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_acc,
    input  logic [$clog2(LEVELS)-1:0] i_acc_bin,
    input  logic                      i_scan,
    input  logic [$clog2(LEVELS)-1:0] i_scan_addr,
    output logic [CNT_W-1:0]          o_scan_data
);
    localparam int AW = $clog2(LEVELS);

    logic [CNT_W-1:0] r_mem [LEVELS];
    logic [CNT_W-1:0] r_rd;
    logic             r_s2_vld;
    logic [AW-1:0]    r_s2_bin;
    logic             r_wb_vld;
    logic [AW-1:0]    r_wb_bin;
    logic [CNT_W-1:0] r_wb_val;

    logic [AW-1:0]    w_rd_addr;
    logic             w_we;
    logic [AW-1:0]    w_wr_addr;
    logic [CNT_W-1:0] w_wr_data;
    logic [CNT_W-1:0] w_inc;

    // Increment: the write that lands at the read edge is not seen by the read,
    // so take it from the write-back register instead
    always_comb begin
        if (r_wb_vld && (r_wb_bin == r_s2_bin)) begin
            w_inc = r_wb_val + CNT_W'(1);
        end else begin
            w_inc = r_rd + CNT_W'(1);
        end
    end

    // Port muxing: scan and accumulate never overlap
    assign w_rd_addr = i_scan ? i_scan_addr : i_acc_bin;
    assign w_we      = i_scan || r_s2_vld;
    assign w_wr_addr = i_scan ? i_scan_addr : r_s2_bin;
    assign w_wr_data = i_scan ? '0 : w_inc;

    // Memory: registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_wb_vld <= 1'b0;
        end else begin
            r_s2_vld <= i_acc;
            r_wb_vld <= r_s2_vld;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        r_s2_bin <= i_acc_bin;
        r_wb_bin <= r_s2_bin;
        r_wb_val <= w_inc;
    end

    assign o_scan_data = r_rd;

endmodule

// File: src/otsu_mul.sv
// Shared shift-add multiplier: one multiplier bit per cycle, stops early once
// the remaining multiplier bits are zero. No dependencies.
module otsu_mul #(
    parameter int A_W = 118,
    parameter int B_W = 42
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [A_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    output logic           o_done,
    output logic [A_W-1:0] o_prod
);
    logic           r_run;
    logic [A_W-1:0] r_a;
    logic [B_W-1:0] r_b;
    logic [A_W-1:0] r_acc;

    // Run flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_start) begin
            r_run <= 1'b1;
        end else if (r_run && (r_b == '0)) begin
            r_run <= 1'b0;
        end
    end

    // Shift-add datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_run && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_run && (r_b == '0);
    assign o_prod = r_acc;

endmodule

// File: src/otsu_threshold_finder_unit.sv
// Otsu threshold finder, top level: sequencer, class accumulators and result register.
// Depends on otsu_pkg, otsu_if, otsu_hist and otsu_mul.
//
// After reset the block runs a clearing pass over the histogram and takes no
// pixels meanwhile. Pixels are then taken one per clock, except while a search
// runs, into a LEVELS-bin histogram; pixels past MAX_PIXELS in a frame are
// dropped and pixels at or above LEVELS land in the top bin. The request marked
// last starts the search: the histogram pipeline drains, then each threshold is
// tried in turn on a single shift-add multiplier that retires one multiplier bit
// per cycle. A threshold takes up to seven products, whose multiplier operands
// are t, N, n0, n1, d, best p and p; an empty-class threshold stops after the
// first. The histogram is cleared during the same scan. The result (threshold,
// found) waits in an output register, so the next frame's pixels are taken while
// it is unclaimed; a new search ends only once the previous result has gone. The
// variance compare is exact: d^2 * p_best against d_best^2 * p, with
// d = |s0*N - S*n0| and p = n0*n1; the first maximum wins.
module otsu_threshold_finder_unit #(
    parameter int MAX_PIXELS = 65536,
    parameter int LEVELS     = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    otsu_pix_if.sink      i_pix,
    otsu_res_if.source    o_res
);
    import otsu_pkg::*;

    localparam int LW  = $clog2(LEVELS);
    localparam int CW  = $clog2(MAX_PIXELS + 1);
    localparam int SW  = CW + LW;
    localparam int DW  = SW + CW;
    localparam int PPW = 2 * CW;
    localparam int D2W = 2 * DW;
    localparam int PW  = D2W + PPW;
    localparam int XW  = LW + PIXEL_W + 1;

    localparam logic [LW-1:0] LAST_BIN = LW'(LEVELS - 1);
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_PIXELS);

    t_state           r_state;
    t_state           n_state;
    logic [LW-1:0]    r_t;
    logic             r_go;
    logic [CW-1:0]    r_n_pix;
    logic [SW-1:0]    r_lsum;
    logic [CW-1:0]    r_n0;
    logic [SW-1:0]    r_s0;
    logic [CW-1:0]    r_h;
    logic [DW-1:0]    r_a;
    logic [DW-1:0]    r_d;
    logic [PPW-1:0]   r_p;
    logic [D2W-1:0]   r_d2;
    logic [PW-1:0]    r_l;
    logic [D2W-1:0]   r_best_d2;
    logic [PPW-1:0]   r_best_p;
    logic [LW-1:0]    r_best_t;
    logic             r_found;
    logic             r_o_vld;
    logic [THR_W-1:0] r_o_thr;
    logic             r_o_found;

    logic [XW-1:0]    w_px_ext;
    logic [LW-1:0]    w_bin;
    logic             w_accept;
    logic             w_count;
    logic [CW-1:0]    w_n1;
    logic [CW-1:0]    w_hdata;
    logic             w_scan;
    logic             w_ready;
    logic             w_is_mul;
    logic             w_mul_start;
    logic [PW-1:0]    w_mul_a;
    logic [DW-1:0]    w_mul_b;
    logic             w_mul_done;
    logic [PW-1:0]    w_prod;
    logic [DW-1:0]    w_prod_d;
    logic             w_post;

    // Bin select with clamp to the top bin
    assign w_px_ext = XW'(i_pix.pixel);
    assign w_bin    = (w_px_ext >= XW'(LEVELS)) ? LAST_BIN : w_px_ext[LW-1:0];

    assign w_accept = i_pix.valid && i_pix.ready;
    assign w_count  = w_accept && (r_n_pix < MAX_CNT);
    assign w_n1     = r_n_pix - r_n0;
    assign w_prod_d = w_prod[DW-1:0];
    assign w_post   = (r_state == ST_NEXT) && (r_t == LAST_BIN) &&
                      (!r_o_vld || o_res.ready);

    otsu_hist #(
        .LEVELS (LEVELS),
        .CNT_W  (CW)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (w_count),
        .i_acc_bin   (w_bin),
        .i_scan      (w_scan),
        .i_scan_addr (r_t),
        .o_scan_data (w_hdata)
    );

    otsu_mul #(
        .A_W (PW),
        .B_W (DW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_t == LAST_BIN) n_state = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (w_accept && i_pix.last) n_state = ST_DRAIN;
            end
            ST_DRAIN: n_state = ST_READ;
            ST_READ:  n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_MUL_TH;
            ST_MUL_TH: begin
                if (w_mul_done) begin
                    n_state = ((r_n0 == '0) || (w_n1 == '0)) ? ST_NEXT : ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                if (w_mul_done) n_state = ST_MUL_B;
            end
            ST_MUL_B: begin
                if (w_mul_done) n_state = ST_MUL_P;
            end
            ST_MUL_P: begin
                if (w_mul_done) n_state = ST_MUL_DD;
            end
            ST_MUL_DD: begin
                if (w_mul_done) n_state = r_found ? ST_MUL_L : ST_NEXT;
            end
            ST_MUL_L: begin
                if (w_mul_done) n_state = ST_MUL_R;
            end
            ST_MUL_R: begin
                if (w_mul_done) n_state = ST_NEXT;
            end
            ST_NEXT: begin
                if (r_t != LAST_BIN) begin
                    n_state = ST_READ;
                end else if (w_post) begin
                    n_state = ST_ACCUM;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Outputs of the sequencer: ports, scan and multiplier operands
    always_comb begin
        w_scan   = 1'b0;
        w_ready  = 1'b0;
        w_is_mul = 1'b0;
        w_mul_a  = '0;
        w_mul_b  = '0;
        case (r_state)
            ST_CLEAR, ST_READ: w_scan = 1'b1;
            ST_ACCUM: w_ready = 1'b1;
            ST_MUL_TH: begin
                w_is_mul = 1'b1;
                w_mul_a  = PW'(r_h);
                w_mul_b  = DW'(r_t);
            end
            ST_MUL_A: begin
                w_is_mul = 1'b1;
                w_mul_a  = PW'(r_s0);
                w_mul_b  = DW'(r_n_pix);
            end
            ST_MUL_B: begin
                w_is_mul = 1'b1;
                w_mul_a  = PW'(r_lsum);
                w_mul_b  = DW'(r_n0);
            end
            ST_MUL_P: begin
                w_is_mul = 1'b1;
                w_mul_a  = PW'(r_n0);
                w_mul_b  = DW'(w_n1);
            end
            ST_MUL_DD: begin
                w_is_mul = 1'b1;
                w_mul_a  = PW'(r_d);
                w_mul_b  = r_d;
            end
            ST_MUL_L: begin
                w_is_mul = 1'b1;
                w_mul_a  = PW'(r_d2);
                w_mul_b  = DW'(r_best_p);
            end
            ST_MUL_R: begin
                w_is_mul = 1'b1;
                w_mul_a  = PW'(r_best_d2);
                w_mul_b  = DW'(r_p);
            end
            default: begin
                w_scan = 1'b0;
            end
        endcase
    end

    assign w_mul_start = w_is_mul && !r_go;
    assign i_pix.ready = w_ready;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_t     <= '0;
            r_go    <= 1'b0;
            r_n_pix <= '0;
            r_lsum  <= '0;
            r_found <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;

            // multiplier handshake
            if (w_mul_start) begin
                r_go <= 1'b1;
            end else if (w_mul_done) begin
                r_go <= 1'b0;
            end

            // threshold / clear index
            if ((r_state == ST_CLEAR) || (r_state == ST_NEXT)) begin
                if (r_t != LAST_BIN) begin
                    r_t <= r_t + LW'(1);
                end else if ((r_state == ST_CLEAR) || w_post) begin
                    r_t <= '0;
                end
            end

            // frame count and level sum
            if (w_count) begin
                r_n_pix <= r_n_pix + CW'(1);
                r_lsum  <= r_lsum + SW'(w_bin);
            end else if (w_post) begin
                r_n_pix <= '0;
                r_lsum  <= '0;
            end

            if (r_state == ST_DRAIN) begin
                r_found <= 1'b0;
            end else if ((r_state == ST_MUL_DD) && w_mul_done) begin
                r_found <= 1'b1;
            end

            // result register: a new result takes the slot the old one leaves
            if (w_post) begin
                r_o_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // Search datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_DRAIN: begin
                r_n0     <= '0;
                r_s0     <= '0;
                r_best_t <= '0;
            end
            ST_LOAD: begin
                r_h  <= w_hdata;
                r_n0 <= r_n0 + w_hdata;
            end
            ST_MUL_TH: begin
                if (w_mul_done) r_s0 <= r_s0 + w_prod[SW-1:0];
            end
            ST_MUL_A: begin
                if (w_mul_done) r_a <= w_prod_d;
            end
            ST_MUL_B: begin
                if (w_mul_done) begin
                    r_d <= (r_a >= w_prod_d) ? (r_a - w_prod_d) : (w_prod_d - r_a);
                end
            end
            ST_MUL_P: begin
                if (w_mul_done) r_p <= w_prod[PPW-1:0];
            end
            ST_MUL_DD: begin
                if (w_mul_done) begin
                    r_d2 <= w_prod[D2W-1:0];
                    // first qualifying threshold is taken as is
                    if (!r_found) begin
                        r_best_d2 <= w_prod[D2W-1:0];
                        r_best_p  <= r_p;
                        r_best_t  <= r_t;
                    end
                end
            end
            ST_MUL_L: begin
                if (w_mul_done) r_l <= w_prod;
            end
            ST_MUL_R: begin
                // strictly greater: first maximum wins
                if (w_mul_done && (r_l > w_prod)) begin
                    r_best_d2 <= r_d2;
                    r_best_p  <= r_p;
                    r_best_t  <= r_t;
                end
            end
            default: begin
                r_h <= r_h;
            end
        endcase
        if (w_post) begin
            r_o_thr   <= THR_W'(r_best_t);
            r_o_found <= r_found;
        end
    end

    assign o_res.valid     = r_o_vld;
    assign o_res.threshold = r_o_thr;
    assign o_res.found     = r_o_found;

    // Checks
    a_scan_vs_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_scan && w_count))
        else $error("histogram scan and pixel update in the same cycle");

    a_post_from_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_vld) |-> ($past(r_state) == ST_NEXT))
        else $error("result posted outside the end of a search");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.found) |-> (o_res.threshold == '0))
        else $error("threshold nonzero with found clear");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n_pix <= MAX_CNT)
        else $error("frame pixel count past its limit");

endmodule
